// ===== rtl/weighted_path_order_compare_defines.svh =====
// assertion macros shared by the weighted path order compare rtl
// no dependencies; included by the modules that carry assertions
`ifndef WEIGHTED_PATH_ORDER_COMPARE_DEFINES_SVH
`define WEIGHTED_PATH_ORDER_COMPARE_DEFINES_SVH

// same-cycle implication, off during reset
`define WPOC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, off during reset
`define WPOC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/wpoc_pkg.sv =====
// shared types and constants of the weighted path order compare block
// no dependencies
`timescale 1ns / 1ps

package wpoc_pkg;

   localparam int EDGE_ID_WIDTH = 8;
   localparam int EDGE_IDS      = 256;
   localparam int COMP_WIDTH    = 2;
   localparam int WEIGHT_WIDTH  = 16;
   localparam int SUM_WIDTH     = 32;
   localparam int ORDER_WIDTH   = 2;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_PATH = 1'b1;

   localparam logic [ORDER_WIDTH-1:0] ORD_LT = 2'd0;
   localparam logic [ORDER_WIDTH-1:0] ORD_EQ = 2'd1;
   localparam logic [ORDER_WIDTH-1:0] ORD_GT = 2'd2;

   // per-position control that travels from front to back
   typedef struct packed {
      logic                     last;
      logic                     a_present;
      logic                     b_present;
      logic                     a_weighed;
      logic                     b_weighed;
      logic [EDGE_ID_WIDTH-1:0] edge_a;
      logic [EDGE_ID_WIDTH-1:0] edge_b;
   } pos_ctrl_type;

endpackage

// ===== rtl/wpoc_ram.sv =====
// generic single-write, dual-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module wpoc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== rtl/wpoc_front.sv =====
// front end: accepts words, writes the weight banks, looks up both edges
// depends on wpoc_pkg and wpoc_ram
`timescale 1ns / 1ps

module wpoc_front #(
   parameter int WEIGHT_COUNT = 4,
   parameter int EDGE_COUNT   = 256,
   parameter int QUEUE_DEPTH  = 4,
   localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_action,
   input  logic [wpoc_pkg::EDGE_ID_WIDTH-1:0]    req_load_edge,
   input  logic [wpoc_pkg::COMP_WIDTH-1:0]       req_load_component,
   input  logic [wpoc_pkg::WEIGHT_WIDTH-1:0]     req_load_value,
   input  logic [wpoc_pkg::EDGE_ID_WIDTH-1:0]    req_edge_a,
   input  logic                                  req_a_present,
   input  logic [wpoc_pkg::EDGE_ID_WIDTH-1:0]    req_edge_b,
   input  logic                                  req_b_present,
   input  logic                                  req_last,
   input  logic [CW-1:0]                         q_count,
   output logic                                  s1_valid,
   output wpoc_pkg::pos_ctrl_type                s1_ctrl,
   output logic [WEIGHT_COUNT-1:0][wpoc_pkg::WEIGHT_WIDTH-1:0] s1_wa,
   output logic [WEIGHT_COUNT-1:0][wpoc_pkg::WEIGHT_WIDTH-1:0] s1_wb
);

   localparam int TABLE_DEPTH =
      (EDGE_COUNT < wpoc_pkg::EDGE_IDS) ? EDGE_COUNT : wpoc_pkg::EDGE_IDS;
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic                   accept;
   logic                   pos_accept;
   logic                   load_ok;
   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   wpoc_pkg::pos_ctrl_type s1_ctrl_ff;
   wpoc_pkg::pos_ctrl_type s1_ctrl_in;

   // credit check: the word in flight plus those queued must fit
   assign req_stall  = (int'(q_count) + int'(s1_valid_ff)) >= QUEUE_DEPTH;
   assign accept     = req_valid && !req_stall;
   assign pos_accept = accept && (req_action == wpoc_pkg::ACT_PATH);
   assign load_ok    = accept && (req_action == wpoc_pkg::ACT_LOAD) &&
                       (int'(req_load_edge) < EDGE_COUNT);

   always_comb begin
      s1_valid_in          = pos_accept;
      s1_ctrl_in.last      = req_last;
      s1_ctrl_in.a_present = req_a_present;
      s1_ctrl_in.b_present = req_b_present;
      // ids past the table weigh nothing
      s1_ctrl_in.a_weighed = req_a_present && (int'(req_edge_a) < EDGE_COUNT);
      s1_ctrl_in.b_weighed = req_b_present && (int'(req_edge_b) < EDGE_COUNT);
      s1_ctrl_in.edge_a    = req_edge_a;
      s1_ctrl_in.edge_b    = req_edge_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (pos_accept) begin
         s1_ctrl_ff <= s1_ctrl_in;
      end
   end

   // one bank per component, both paths read in the same cycle
   for (genvar j = 0; j < WEIGHT_COUNT; j++) begin : g_bank
      logic bank_we;
      assign bank_we = load_ok && (int'(req_load_component) == j);

      wpoc_ram #(
         .WIDTH (wpoc_pkg::WEIGHT_WIDTH),
         .DEPTH (TABLE_DEPTH)
      ) u_bank (
         .clock     (clock),
         .wr_en     (bank_we),
         .wr_addr   (req_load_edge[AW-1:0]),
         .wr_data   (req_load_value),
         .rd_en     (pos_accept),
         .rd_addr_a (req_edge_a[AW-1:0]),
         .rd_addr_b (req_edge_b[AW-1:0]),
         .rd_data_a (s1_wa[j]),
         .rd_data_b (s1_wb[j])
      );
   end

   assign s1_valid = s1_valid_ff;
   assign s1_ctrl  = s1_ctrl_ff;

endmodule

// ===== rtl/wpoc_queue.sv =====
// short word queue between front and back
// depends on the assertion macro header
`timescale 1ns / 1ps
`include "weighted_path_order_compare_defines.svh"

module wpoc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty,
   output logic [CW-1:0]    count
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff;
   logic [PW-1:0]    rd_ptr_in;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data  = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

   // the front's credit check must keep the queue from overflowing
   `WPOC_ASSERT_IMPLY(a_push_room, clock, reset, push && !pop, count_ff < CW'(DEPTH))
   `WPOC_ASSERT_IMPLY(a_pop_data, clock, reset, pop, count_ff != '0)
   `WPOC_ASSERT_NEXT(a_count_track, clock, reset, push && !pop, count_ff != '0)

endmodule

// ===== rtl/wpoc_back.sv =====
// back end: weight sums, length and edge verdicts, final order and output register
// depends on wpoc_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "weighted_path_order_compare_defines.svh"

module wpoc_back #(
   parameter int WEIGHT_COUNT = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  use_weights,
   input  logic                                  q_valid,
   input  wpoc_pkg::pos_ctrl_type                q_ctrl,
   input  logic [WEIGHT_COUNT-1:0][wpoc_pkg::WEIGHT_WIDTH-1:0] q_wa,
   input  logic [WEIGHT_COUNT-1:0][wpoc_pkg::WEIGHT_WIDTH-1:0] q_wb,
   output logic                                  q_pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [wpoc_pkg::ORDER_WIDTH-1:0]      rsp_order
);

   localparam int SW = wpoc_pkg::SUM_WIDTH;
   localparam int WW = wpoc_pkg::WEIGHT_WIDTH;
   localparam int OW = wpoc_pkg::ORDER_WIDTH;

   logic [WEIGHT_COUNT-1:0][SW-1:0] sum_a_ff, sum_a_in, sat_a;
   logic [WEIGHT_COUNT-1:0][SW-1:0] sum_b_ff, sum_b_in, sat_b;
   logic [WEIGHT_COUNT-1:0][SW-1:0] snap_a_ff, snap_a_in;
   logic [WEIGHT_COUNT-1:0][SW-1:0] snap_b_ff, snap_b_in;
   logic [OW-1:0] len_ff, len_in, len_next;
   logic [OW-1:0] edg_ff, edg_in, edg_next;
   logic [OW-1:0] snap_len_ff, snap_len_in;
   logic [OW-1:0] snap_edg_ff, snap_edg_in;
   logic          b_valid_ff, b_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0] rsp_order_ff, rsp_order_in;
   logic          b_move;
   logic          b_free;
   logic          pop;
   logic          finish;
   logic [OW-1:0] final_order;
   logic          wt_decided;
   logic [OW-1:0] wt_order;

   assign b_move = b_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign b_free = !b_valid_ff || b_move;
   // only a last word needs the result slot, others never wait
   assign pop    = q_valid && (!q_ctrl.last || b_free);
   assign finish = pop && q_ctrl.last;

   // saturating per-component sums
   for (genvar j = 0; j < WEIGHT_COUNT; j++) begin : g_lane
      logic [SW:0] wide_a;
      logic [SW:0] wide_b;
      assign wide_a = {1'b0, sum_a_ff[j]} +
                      {{(SW + 1 - WW){1'b0}}, (q_ctrl.a_weighed ? q_wa[j] : {WW{1'b0}})};
      assign wide_b = {1'b0, sum_b_ff[j]} +
                      {{(SW + 1 - WW){1'b0}}, (q_ctrl.b_weighed ? q_wb[j] : {WW{1'b0}})};
      assign sat_a[j] = wide_a[SW] ? {SW{1'b1}} : wide_a[SW-1:0];
      assign sat_b[j] = wide_b[SW] ? {SW{1'b1}} : wide_b[SW-1:0];
   end

   always_comb begin
      len_next = len_ff;
      edg_next = edg_ff;
      if (q_ctrl.a_present && !q_ctrl.b_present) begin
         len_next = wpoc_pkg::ORD_GT;
      end else if (q_ctrl.b_present && !q_ctrl.a_present) begin
         len_next = wpoc_pkg::ORD_LT;
      end else if (q_ctrl.a_present && q_ctrl.b_present &&
                   (edg_ff == wpoc_pkg::ORD_EQ) && (q_ctrl.edge_a != q_ctrl.edge_b)) begin
         edg_next = (q_ctrl.edge_a < q_ctrl.edge_b) ? wpoc_pkg::ORD_LT : wpoc_pkg::ORD_GT;
      end
   end

   always_comb begin
      sum_a_in    = sum_a_ff;
      sum_b_in    = sum_b_ff;
      len_in      = len_ff;
      edg_in      = edg_ff;
      snap_a_in   = snap_a_ff;
      snap_b_in   = snap_b_ff;
      snap_len_in = snap_len_ff;
      snap_edg_in = snap_edg_ff;
      if (finish) begin
         // hand the run to the result stage and start afresh
         snap_a_in   = sat_a;
         snap_b_in   = sat_b;
         snap_len_in = len_next;
         snap_edg_in = edg_next;
         sum_a_in    = '0;
         sum_b_in    = '0;
         len_in      = wpoc_pkg::ORD_EQ;
         edg_in      = wpoc_pkg::ORD_EQ;
      end else if (pop) begin
         sum_a_in = sat_a;
         sum_b_in = sat_b;
         len_in   = len_next;
         edg_in   = edg_next;
      end
   end

   // first differing component decides, lowest index first
   always_comb begin
      wt_decided = 1'b0;
      wt_order   = wpoc_pkg::ORD_EQ;
      for (int j = WEIGHT_COUNT - 1; j >= 0; j--) begin
         if (snap_a_ff[j] != snap_b_ff[j]) begin
            wt_decided = 1'b1;
            wt_order   = (snap_a_ff[j] > snap_b_ff[j]) ? wpoc_pkg::ORD_GT : wpoc_pkg::ORD_LT;
         end
      end
   end

   always_comb begin
      if (use_weights && wt_decided) begin
         final_order = wt_order;
      end else if (snap_len_ff != wpoc_pkg::ORD_EQ) begin
         final_order = snap_len_ff;
      end else begin
         final_order = snap_edg_ff;
      end
   end

   always_comb begin
      b_valid_in   = finish || (b_valid_ff && !b_move);
      rsp_valid_in = b_move || (rsp_valid_ff && rsp_stall);
      rsp_order_in = b_move ? final_order : rsp_order_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_a_ff     <= '0;
         sum_b_ff     <= '0;
         len_ff       <= wpoc_pkg::ORD_EQ;
         edg_ff       <= wpoc_pkg::ORD_EQ;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_a_ff     <= sum_a_in;
         sum_b_ff     <= sum_b_in;
         len_ff       <= len_in;
         edg_ff       <= edg_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      snap_a_ff    <= snap_a_in;
      snap_b_ff    <= snap_b_in;
      snap_len_ff  <= snap_len_in;
      snap_edg_ff  <= snap_edg_in;
      rsp_order_ff <= rsp_order_in;
   end

   assign q_pop     = pop;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_order = rsp_order_ff;

   `WPOC_ASSERT_NEXT(a_run_cleared, clock, reset, finish, (sum_a_ff == '0) && (sum_b_ff == '0) && (len_ff == wpoc_pkg::ORD_EQ) && (edg_ff == wpoc_pkg::ORD_EQ))
   `WPOC_ASSERT_NEXT(a_result_staged, clock, reset, finish, b_valid_ff)

endmodule

// ===== rtl/weighted_path_order_compare.sv =====
// weighted path order compare: one word per cycle while req_stall is low,
// front and back parted by a four-word queue. a result passes the s1 register,
// queue, snapshot and rsp register; the rate is set by the sum update and the
// dual-read weight banks (one per component). synchronous reset clears the
// queue, sums, verdicts and use_weights; the weight table is not cleared.
// depends on wpoc_pkg, wpoc_front, wpoc_queue, wpoc_back
`timescale 1ns / 1ps

module weighted_path_order_compare #(
   parameter int WEIGHT_COUNT = 4,
   parameter int EDGE_COUNT   = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic                                csr_write_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [wpoc_pkg::EDGE_ID_WIDTH-1:0]  req_load_edge,
   input  logic [wpoc_pkg::COMP_WIDTH-1:0]     req_load_component,
   input  logic [wpoc_pkg::WEIGHT_WIDTH-1:0]   req_load_value,
   input  logic [wpoc_pkg::EDGE_ID_WIDTH-1:0]  req_edge_a,
   input  logic                                req_a_present,
   input  logic [wpoc_pkg::EDGE_ID_WIDTH-1:0]  req_edge_b,
   input  logic                                req_b_present,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [wpoc_pkg::ORDER_WIDTH-1:0]    rsp_order
);

   localparam int QUEUE_DEPTH = 4;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int QW = $bits(wpoc_pkg::pos_ctrl_type) +
                       2 * WEIGHT_COUNT * wpoc_pkg::WEIGHT_WIDTH;

   logic use_weights_ff;
   logic use_weights_in;

   logic                   s1_valid;
   wpoc_pkg::pos_ctrl_type s1_ctrl;
   logic [WEIGHT_COUNT-1:0][wpoc_pkg::WEIGHT_WIDTH-1:0] s1_wa;
   logic [WEIGHT_COUNT-1:0][wpoc_pkg::WEIGHT_WIDTH-1:0] s1_wb;

   logic                   q_valid;
   logic                   q_pop;
   logic [CW-1:0]          q_count;
   logic [QW-1:0]          q_rd_data;
   wpoc_pkg::pos_ctrl_type q_ctrl;
   logic [WEIGHT_COUNT-1:0][wpoc_pkg::WEIGHT_WIDTH-1:0] q_wa;
   logic [WEIGHT_COUNT-1:0][wpoc_pkg::WEIGHT_WIDTH-1:0] q_wb;

   assign use_weights_in = csr_write_enable ? csr_write_data : use_weights_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_weights_ff <= 1'b0;
      end else begin
         use_weights_ff <= use_weights_in;
      end
   end

   wpoc_front #(
      .WEIGHT_COUNT (WEIGHT_COUNT),
      .EDGE_COUNT   (EDGE_COUNT),
      .QUEUE_DEPTH  (QUEUE_DEPTH)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_load_edge      (req_load_edge),
      .req_load_component (req_load_component),
      .req_load_value     (req_load_value),
      .req_edge_a         (req_edge_a),
      .req_a_present      (req_a_present),
      .req_edge_b         (req_edge_b),
      .req_b_present      (req_b_present),
      .req_last           (req_last),
      .q_count            (q_count),
      .s1_valid           (s1_valid),
      .s1_ctrl            (s1_ctrl),
      .s1_wa              (s1_wa),
      .s1_wb              (s1_wb)
   );

   wpoc_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid),
      .push_data ({s1_ctrl, s1_wa, s1_wb}),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .not_empty (q_valid),
      .count     (q_count)
   );

   assign {q_ctrl, q_wa, q_wb} = q_rd_data;

   wpoc_back #(
      .WEIGHT_COUNT (WEIGHT_COUNT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .use_weights (use_weights_ff),
      .q_valid     (q_valid),
      .q_ctrl      (q_ctrl),
      .q_wa        (q_wa),
      .q_wb        (q_wb),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_order   (rsp_order)
   );

endmodule

// ===== verif/weighted_path_order_compare_checker.sv =====
`timescale 1ns / 1ps
// checker for weighted_path_order_compare: watches csr, request and response words,
// predicts each order from its own copy of the weight table and sums, compares in order
// depends on wpoc_pkg
module weighted_path_order_compare_checker #(
   parameter int WEIGHT_COUNT = 4,
   parameter int EDGE_COUNT   = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic                                csr_write_data,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_action,
   input  logic [wpoc_pkg::EDGE_ID_WIDTH-1:0]  req_load_edge,
   input  logic [wpoc_pkg::COMP_WIDTH-1:0]     req_load_component,
   input  logic [wpoc_pkg::WEIGHT_WIDTH-1:0]   req_load_value,
   input  logic [wpoc_pkg::EDGE_ID_WIDTH-1:0]  req_edge_a,
   input  logic                                req_a_present,
   input  logic [wpoc_pkg::EDGE_ID_WIDTH-1:0]  req_edge_b,
   input  logic                                req_b_present,
   input  logic                                req_last,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [wpoc_pkg::ORDER_WIDTH-1:0]    rsp_order,
   output int                                  mismatch_count,
   output int                                  orders_pending,
   output int                                  orders_checked
);
   import wpoc_pkg::*;

   localparam int MAX_REPORTS = 10;

   logic [WEIGHT_WIDTH-1:0] weights [EDGE_COUNT*WEIGHT_COUNT];
   logic [SUM_WIDTH-1:0]    sum_a [WEIGHT_COUNT];
   logic [SUM_WIDTH-1:0]    sum_b [WEIGHT_COUNT];
   logic [ORDER_WIDTH-1:0]  length_order;
   logic [ORDER_WIDTH-1:0]  edge_order;
   logic                    weighted;
   logic [ORDER_WIDTH-1:0]  expected_orders [$];
   int                      errors = 0;
   int                      checked = 0;

   initial begin
      for (int i = 0; i < EDGE_COUNT*WEIGHT_COUNT; i++) weights[i] = '0;
   end

   function automatic void clear_run();
      for (int j = 0; j < WEIGHT_COUNT; j++) begin
         sum_a[j] = '0;
         sum_b[j] = '0;
      end
      length_order = ORD_EQ;
      edge_order   = ORD_EQ;
   endfunction

   function automatic logic [SUM_WIDTH-1:0] add_saturating(input logic [SUM_WIDTH-1:0] s,
                                                           input logic [WEIGHT_WIDTH-1:0] w);
      logic [SUM_WIDTH:0] t;
      t = {1'b0, s} + w;
      return t[SUM_WIDTH] ? '1 : t[SUM_WIDTH-1:0];
   endfunction

   function automatic void add_path_edge(input bit first,
                                         input logic [EDGE_ID_WIDTH-1:0] id);
      int base;
      // ids beyond the table weigh nothing
      if (id >= EDGE_COUNT) return;
      base = int'(id) * WEIGHT_COUNT;
      for (int j = 0; j < WEIGHT_COUNT; j++) begin
         if (first) sum_a[j] = add_saturating(sum_a[j], weights[base + j]);
         else sum_b[j] = add_saturating(sum_b[j], weights[base + j]);
      end
   endfunction

   function automatic logic [ORDER_WIDTH-1:0] settled_order();
      if (weighted) begin
         for (int j = 0; j < WEIGHT_COUNT; j++) begin
            if (sum_a[j] > sum_b[j]) return ORD_GT;
            if (sum_a[j] < sum_b[j]) return ORD_LT;
         end
      end
      if (length_order != ORD_EQ) return length_order;
      return edge_order;
   endfunction

   function automatic void advance_comparison();
      if (req_action == ACT_LOAD) begin
         if (req_load_edge < EDGE_COUNT && req_load_component < WEIGHT_COUNT)
            weights[int'(req_load_edge) * WEIGHT_COUNT + int'(req_load_component)] =
               req_load_value;
         return;
      end
      if (req_a_present) add_path_edge(1'b1, req_edge_a);
      if (req_b_present) add_path_edge(1'b0, req_edge_b);
      // latest one-sided position decides length, first differing pair decides edge order
      if (req_a_present && !req_b_present) length_order = ORD_GT;
      else if (req_b_present && !req_a_present) length_order = ORD_LT;
      else if (req_a_present && req_b_present && edge_order == ORD_EQ &&
               req_edge_a != req_edge_b)
         edge_order = (req_edge_a < req_edge_b) ? ORD_LT : ORD_GT;
      if (req_last) begin
         expected_orders.push_back(settled_order());
         clear_run();
      end
   endfunction

   function automatic void check_order();
      logic [ORDER_WIDTH-1:0] want;
      if (expected_orders.size() == 0) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("unexpected order word %0d with nothing pending at %0t",
                     rsp_order, $time);
      end else begin
         want = expected_orders.pop_front();
         checked++;
         if (rsp_order !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("order mismatch at %0t: expected %0d, got %0d",
                        $time, want, rsp_order);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_run();
         weighted = 1'b0;
         expected_orders.delete();
      end else begin
         if (csr_write_enable) weighted = csr_write_data;
         if (req_valid && !req_stall) advance_comparison();
         if (rsp_valid && !rsp_stall) check_order();
      end
      mismatch_count <= errors;
      orders_pending <= expected_orders.size();
      orders_checked <= checked;
   end

endmodule

// ===== verif/weighted_path_order_compare_tb.sv =====
`timescale 1ns / 1ps
// testbench top for weighted_path_order_compare: clock, reset, word stimulus and verdict
// depends on wpoc_pkg, weighted_path_order_compare and weighted_path_order_compare_checker
module weighted_path_order_compare_tb;
   import wpoc_pkg::*;

   localparam int WEIGHT_COUNT  = 4;
   localparam int EDGE_COUNT    = 256;
   localparam int MAX_POS       = 8;
   localparam int RUN_POSITIONS = 24;
   localparam int PHASE_WORDS   = 220;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic                     action;
      logic [EDGE_ID_WIDTH-1:0] load_edge;
      logic [COMP_WIDTH-1:0]    load_component;
      logic [WEIGHT_WIDTH-1:0]  load_value;
      logic [EDGE_ID_WIDTH-1:0] edge_a;
      logic                     a_present;
      logic [EDGE_ID_WIDTH-1:0] edge_b;
      logic                     b_present;
      logic                     last;
   } req_word_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_write_enable = 1'b0;
   logic                     csr_write_data = 1'b0;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_action = ACT_LOAD;
   logic [EDGE_ID_WIDTH-1:0] req_load_edge = '0;
   logic [COMP_WIDTH-1:0]    req_load_component = '0;
   logic [WEIGHT_WIDTH-1:0]  req_load_value = '0;
   logic [EDGE_ID_WIDTH-1:0] req_edge_a = '0;
   logic                     req_a_present = 1'b0;
   logic [EDGE_ID_WIDTH-1:0] req_edge_b = '0;
   logic                     req_b_present = 1'b0;
   logic                     req_last = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [ORDER_WIDTH-1:0]   rsp_order;

   int mismatch_count;
   int orders_pending;
   int orders_checked;

   int idle_pct = 0;
   int stall_pct = 0;
   int words_sent = 0;
   int loads_sent = 0;

   // an edge may be presented only once all its components are loaded
   bit                       loaded [EDGE_COUNT][WEIGHT_COUNT];
   bit                       usable_flag [EDGE_COUNT];
   logic [EDGE_ID_WIDTH-1:0] usable [$];

   weighted_path_order_compare #(
      .WEIGHT_COUNT (WEIGHT_COUNT),
      .EDGE_COUNT   (EDGE_COUNT)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_load_edge      (req_load_edge),
      .req_load_component (req_load_component),
      .req_load_value     (req_load_value),
      .req_edge_a         (req_edge_a),
      .req_a_present      (req_a_present),
      .req_edge_b         (req_edge_b),
      .req_b_present      (req_b_present),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_order          (rsp_order)
   );

   weighted_path_order_compare_checker #(
      .WEIGHT_COUNT (WEIGHT_COUNT),
      .EDGE_COUNT   (EDGE_COUNT)
   ) u_checker (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_load_edge      (req_load_edge),
      .req_load_component (req_load_component),
      .req_load_value     (req_load_value),
      .req_edge_a         (req_edge_a),
      .req_a_present      (req_a_present),
      .req_edge_b         (req_edge_b),
      .req_b_present      (req_b_present),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_order          (rsp_order),
      .mismatch_count     (mismatch_count),
      .orders_pending     (orders_pending),
      .orders_checked     (orders_checked)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   initial begin
      #8000000;
      $display("run did not finish in time, %0d orders still pending", orders_pending);
      $display("FAIL weighted_path_order_compare");
      $finish;
   end

   task automatic send_word(input req_word_type w);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_action         <= w.action;
      req_load_edge      <= w.load_edge;
      req_load_component <= w.load_component;
      req_load_value     <= w.load_value;
      req_edge_a         <= w.edge_a;
      req_a_present      <= w.a_present;
      req_edge_b         <= w.edge_b;
      req_b_present      <= w.b_present;
      req_last           <= w.last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   task automatic load_word(input logic [EDGE_ID_WIDTH-1:0] id,
                            input logic [COMP_WIDTH-1:0] comp,
                            input logic [WEIGHT_WIDTH-1:0] value,
                            input bit with_last);
      req_word_type w;
      bit           full;
      w.action         = ACT_LOAD;
      w.load_edge      = id;
      w.load_component = comp;
      w.load_value     = value;
      w.edge_a         = EDGE_ID_WIDTH'($urandom);
      w.a_present      = 1'($urandom);
      w.edge_b         = EDGE_ID_WIDTH'($urandom);
      w.b_present      = 1'($urandom);
      w.last           = with_last;
      send_word(w);
      loads_sent++;
      loaded[id][comp] = 1'b1;
      full = 1'b1;
      for (int c = 0; c < WEIGHT_COUNT; c++) full &= loaded[id][c];
      if (full && !usable_flag[id]) begin
         usable_flag[id] = 1'b1;
         usable.push_back(id);
      end
   endtask

   task automatic send_position(input bit a_on, input logic [EDGE_ID_WIDTH-1:0] ea,
                                input bit b_on, input logic [EDGE_ID_WIDTH-1:0] eb,
                                input bit is_last);
      req_word_type w;
      w.action         = ACT_PATH;
      w.load_edge      = EDGE_ID_WIDTH'($urandom);
      w.load_component = COMP_WIDTH'($urandom);
      w.load_value     = WEIGHT_WIDTH'($urandom);
      // absent sides carry junk ids, never weighed
      w.a_present      = a_on;
      w.edge_a         = a_on ? ea : EDGE_ID_WIDTH'($urandom);
      w.b_present      = b_on;
      w.edge_b         = b_on ? eb : EDGE_ID_WIDTH'($urandom);
      w.last           = is_last;
      send_word(w);
   endtask

   function automatic logic [EDGE_ID_WIDTH-1:0] pick_edge();
      return usable[$urandom_range(usable.size() - 1)];
   endfunction

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (orders_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input bit weights_on);
      csr_write_enable <= 1'b1;
      csr_write_data   <= weights_on;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_compare();
      int                       mode;
      int                       n;
      int                       la;
      int                       lb;
      int                       pick;
      bit                       a_on [MAX_POS];
      bit                       b_on [MAX_POS];
      logic [EDGE_ID_WIDTH-1:0] a_id [MAX_POS];
      logic [EDGE_ID_WIDTH-1:0] b_id [MAX_POS];
      logic [EDGE_ID_WIDTH-1:0] swap;
      mode = $urandom_range(99);
      la = $urandom_range(MAX_POS - 2);
      lb = la;
      for (int k = 0; k < MAX_POS; k++) begin
         a_id[k] = pick_edge();
         b_id[k] = pick_edge();
      end
      if (mode < 35) begin
         lb = $urandom_range(MAX_POS - 2);
      end else if (mode < 60) begin
         b_id = a_id;
         if ($urandom_range(1)) b_id[$urandom_range(MAX_POS - 1)] = pick_edge();
         if ($urandom_range(1)) lb = $urandom_range(MAX_POS - 2);
      end else if (mode < 80) begin
         // same multiset of edges: weights tie, falls through to edge order
         b_id = a_id;
         for (int k = la - 1; k > 0; k--) begin
            pick = $urandom_range(k);
            swap = b_id[k];
            b_id[k] = b_id[pick];
            b_id[pick] = swap;
         end
      end else if (mode < 90) begin
         b_id = a_id;
      end
      n = (la > lb) ? la : lb;
      if (n == 0 || $urandom_range(9) == 0) n++;
      for (int k = 0; k < MAX_POS; k++) begin
         a_on[k] = (k < la);
         b_on[k] = (k < lb);
         if (mode >= 90) begin
            a_on[k] = 1'($urandom);
            b_on[k] = 1'($urandom);
         end
      end
      for (int k = 0; k < n; k++)
         send_position(a_on[k], a_id[k], b_on[k], b_id[k], k == n - 1);
   endtask

   task automatic run_phase(input bit weights_on, input int send_gap, input int recv_gap);
      int start;
      int roll;
      settle();
      write_mode(weights_on);
      idle_pct  = send_gap;
      stall_pct = recv_gap;
      start = words_sent;
      while (words_sent - start < PHASE_WORDS) begin
         if ($urandom_range(9) < 2) begin
            roll = $urandom_range(3);
            load_word(EDGE_ID_WIDTH'($urandom), COMP_WIDTH'($urandom),
                      (roll == 0) ? 16'h0000 : (roll == 1) ? 16'hFFFF
                                             : WEIGHT_WIDTH'($urandom),
                      1'($urandom));
         end else begin
            random_compare();
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // edge 0 weighs nothing, edge 255 weighs the most, edge 1 small and uneven
      for (int c = 0; c < WEIGHT_COUNT; c++) begin
         load_word(8'd0, COMP_WIDTH'(c), 16'h0000, 1'b0);
         load_word(8'd255, COMP_WIDTH'(c), 16'hFFFF, 1'b1);
         load_word(8'd1, COMP_WIDTH'(c), WEIGHT_WIDTH'(c + 1), 1'b0);
      end
      // reset setting: length then edge order
      send_position(1'b0, 8'd0, 1'b0, 8'd0, 1'b1);
      send_position(1'b1, 8'd0, 1'b1, 8'd255, 1'b1);
      send_position(1'b1, 8'd255, 1'b1, 8'd255, 1'b0);
      send_position(1'b1, 8'd0, 1'b0, 8'd0, 1'b1);
      send_position(1'b1, 8'd1, 1'b0, 8'd0, 1'b0);
      send_position(1'b0, 8'd0, 1'b1, 8'd1, 1'b1);
      send_position(1'b1, 8'd255, 1'b1, 8'd0, 1'b1);
      settle();
      write_mode(1'b1);
      send_position(1'b1, 8'd255, 1'b1, 8'd0, 1'b1);
      send_position(1'b1, 8'd0, 1'b1, 8'd1, 1'b0);
      send_position(1'b1, 8'd1, 1'b1, 8'd0, 1'b1);
      send_position(1'b1, 8'd0, 1'b1, 8'd0, 1'b0);
      send_position(1'b0, 8'd0, 1'b1, 8'd0, 1'b1);

      // the first component ties over a long run, the second one then decides
      for (int c = 0; c < WEIGHT_COUNT; c++) begin
         load_word(8'd2, COMP_WIDTH'(c), (c == 0) ? 16'hFFFF : 16'h0000, 1'b0);
         load_word(8'd3, COMP_WIDTH'(c),
                   (c == 0) ? 16'hFFFF : (c == 1) ? 16'h0001 : 16'h0000, 1'b0);
      end
      for (int k = 0; k < RUN_POSITIONS; k++)
         send_position(1'b1, 8'd2, 1'b1, 8'd3, k == RUN_POSITIONS - 1);

      run_phase(1'b0, 0, 0);
      run_phase(1'b1, 60, 0);
      run_phase(1'b0, 0, 60);
      run_phase(1'b1, 34, 34);
      settle();

      $display("sent %0d words (%0d table loads, one %0d-position tie run), %0d orders checked",
               words_sent, loads_sent, RUN_POSITIONS, orders_checked);
      $display("both weight modes under no gaps, sender gaps, receiver stalls and both");
      if (mismatch_count == 0 && orders_pending == 0) begin
         $display("PASS weighted_path_order_compare");
      end else begin
         $display("FAIL weighted_path_order_compare");
      end
      $finish;
   end

endmodule
